>>> rtl/tape_level_run_encoder_defines.svh
// ----------------------------------------------------------------------------
// Tape level run encoder - assertion macros
// Shared property forms for the checker; clk and rst_n come from the scope.
// ----------------------------------------------------------------------------
`ifndef TAPE_LEVEL_RUN_ENCODER_DEFINES_SVH
`define TAPE_LEVEL_RUN_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define TLRE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define TLRE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tlre_pkg.sv
// ----------------------------------------------------------------------------
// Tape level run encoder - shared package
// Types, constants and defaults shared by the encoder's front, queue and back.
// ----------------------------------------------------------------------------
`default_nettype none

package tlre_pkg;

  // Field widths
  localparam int SAMPLE_W = 8;
  localparam int COUNT_W  = 15;
  localparam int BYTE_W   = 8;

  // Run counter saturation value
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Defaults for top level parameters and the threshold register
  localparam logic [SAMPLE_W-1:0] DEF_THRESHOLD  = 8'd128;
  localparam int                  DEF_MAX_UNITS  = 7999;
  localparam int                  DEF_CMDQ_DEPTH = 4;

  // Units = floor((count * UNIT_SCALE + ROUND_OFS) / UNIT_DIV)
  localparam int UNIT_SCALE = 400;
  localparam int ROUND_OFS  = 441;
  localparam int UNIT_DIV   = 882;
  localparam int NUM_W      = 24;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_MUL  = (1 << RECIP_SHIFT) / UNIT_DIV;
  localparam int RECIP_W    = 15;
  localparam int QUOT_W     = 15;

  // Zero bytes = units / ZERO_DIV, via reciprocal
  localparam int ZERO_DIV    = 127;
  localparam int ZERO_SHIFT  = 16;
  localparam int ZERO_RECIP  = (1 << ZERO_SHIFT) / ZERO_DIV;
  localparam int ZERO_RCP_W  = 10;
  localparam int REM_W       = 7;

  // Fixed run byte codes
  localparam logic signed [BYTE_W-1:0] LEP_ZERO      = 8'sd0;
  localparam logic signed [BYTE_W-1:0] LEP_ONE       = 8'sd1;
  localparam logic signed [BYTE_W-1:0] LEP_MINUS_ONE = -8'sd1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_value;
    logic                end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic signed [BYTE_W-1:0] lep_byte;
    logic                     last_in_burst;
  } out_item_t;

  // One finished run handed from front to back
  typedef struct packed {
    logic               level_high;  // level of the run
    logic [COUNT_W-1:0] count;       // samples in the run
    logic               last;        // burst of this item ends with this run
    logic               tail;        // emit opposite-level unit byte after run
  } run_cmd_t;

  typedef struct packed {
    logic     push;
    run_cmd_t cmd;
  } cmd_wr_t;

endpackage

`default_nettype wire

>>> rtl/tape_level_run_encoder.sv
// ----------------------------------------------------------------------------
// Tape level run encoder - top level
// Slices audio samples to levels and encodes level runs as signed run bytes.
// ----------------------------------------------------------------------------
// The input side takes one sample per cycle while the run command queue
// (CMDQ_DEPTH entries) has room. Each closed run then passes through the back
// end's unit conversion (fetch, reciprocal multiply, back multiply, correct
// and clamp, zero count estimate and correction) and emits one remainder byte
// and floor(U/127) zero bytes for a run of U units, plus the unit byte of an
// end-of-stream flush that follows a level change. The byte emitter is the
// bottleneck; result bytes wait in a single output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tape_level_run_encoder import tlre_pkg::*; #(
  parameter int MAX_UNITS  = DEF_MAX_UNITS,
  parameter int CMDQ_DEPTH = DEF_CMDQ_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire in_item_t            in_data,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output out_item_t                out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [SAMPLE_W-1:0] cfg_data
);

  cmd_wr_t  q_wr;
  logic     q_full;
  logic     q_empty;
  logic     q_pop;
  run_cmd_t q_head;

  // Slice and count
  tlre_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_wr      (q_wr)
  );

  // Buffer finished runs
  tlre_cmdq #(
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_wr    (q_wr),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_head  (q_head)
  );

  // Convert and emit bytes
  tlre_back #(
    .MAX_UNITS (MAX_UNITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> rtl/tlre_front.sv
// ----------------------------------------------------------------------------
// Tape level run encoder - front end
// Slices samples to a level, counts run lengths and queues finished runs.
// ----------------------------------------------------------------------------
`default_nettype none

module tlre_front import tlre_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire in_item_t            in_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [SAMPLE_W-1:0] cfg_data,
  input  wire logic                q_full,
  output cmd_wr_t                  q_wr
);

  typedef enum logic [1:0] {
    LVL_LOW  = 2'd0,
    LVL_HIGH = 2'd1,
    LVL_NONE = 2'd2
  } level_t;

  logic [SAMPLE_W-1:0] threshold_r;
  level_t              prior_r, prior_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;

  level_t              level;
  logic [COUNT_W-1:0]  count_inc;
  logic                accept;

  assign in_full   = q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_push && !q_full;

  // Classify the sample and decide which runs close
  always_comb begin
    level     = (in_data.sample_value >= threshold_r) ? LVL_HIGH : LVL_LOW;
    count_inc = (count_r != COUNT_MAX) ? count_r + 1'b1 : count_r;
    prior_nxt = prior_r;
    count_nxt = count_r;
    q_wr      = '0;
    if (accept) begin
      count_nxt = count_inc;
      if (level != prior_r) begin
        prior_nxt = level;
        count_nxt = '0;
        if (prior_r != LVL_NONE) begin
          // close the previous run; flush of the new one rides along as tail
          q_wr.push           = 1'b1;
          q_wr.cmd.level_high = (prior_r == LVL_HIGH);
          q_wr.cmd.count      = count_inc;
          q_wr.cmd.last       = !in_data.end_of_stream;
          q_wr.cmd.tail       = in_data.end_of_stream;
        end else if (in_data.end_of_stream) begin
          q_wr.push           = 1'b1;
          q_wr.cmd.level_high = (level == LVL_HIGH);
          q_wr.cmd.count      = '0;
          q_wr.cmd.last       = 1'b1;
          q_wr.cmd.tail       = 1'b0;
        end
      end else if (in_data.end_of_stream) begin
        q_wr.push           = 1'b1;
        q_wr.cmd.level_high = (level == LVL_HIGH);
        q_wr.cmd.count      = count_inc;
        q_wr.cmd.last       = 1'b1;
        q_wr.cmd.tail       = 1'b0;
      end
      if (in_data.end_of_stream) begin
        prior_nxt = LVL_NONE;
        count_nxt = '0;
      end
    end
  end

  // Hold threshold and run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= DEF_THRESHOLD;
      prior_r     <= LVL_NONE;
      count_r     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        threshold_r <= cfg_data;
      end
      prior_r <= prior_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tlre_cmdq.sv
// ----------------------------------------------------------------------------
// Tape level run encoder - run command queue
// Short register queue that decouples the front end from the byte emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module tlre_cmdq import tlre_pkg::*; #(
  parameter int DEPTH = DEF_CMDQ_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cmd_wr_t  q_wr,
  output logic          q_full,
  input  wire logic     q_pop,
  output logic          q_empty,
  output run_cmd_t      q_head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  run_cmd_t         entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] fill_r;
  logic             do_push, do_pop;

  assign q_full  = (fill_r == CNT_W'(DEPTH));
  assign q_empty = (fill_r == '0);
  assign q_head  = entry_r[rd_ptr_r];
  assign do_push = q_wr.push && !q_full;
  assign do_pop  = q_pop && !q_empty;

  // Store incoming commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= q_wr.cmd;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/tlre_back.sv
// ----------------------------------------------------------------------------
// Tape level run encoder - back end
// Converts run counts to units and emits the remainder, zero and tail bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module tlre_back import tlre_pkg::*; #(
  parameter int MAX_UNITS = DEF_MAX_UNITS
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      q_empty,
  input  wire run_cmd_t  q_head,
  output logic           q_pop,
  output logic           out_empty,
  input  wire logic      out_pop,
  output out_item_t      out_data
);

  localparam int UNIT_W  = $clog2(MAX_UNITS + 1);
  localparam int ZERO_W  = (MAX_UNITS / ZERO_DIV > 0) ? $clog2(MAX_UNITS / ZERO_DIV + 1) : 1;
  localparam int RPROD_W = NUM_W + RECIP_W;
  localparam int ZPROD_W = UNIT_W + ZERO_RCP_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RECIP,
    S_MULQ,
    S_FIX,
    S_ZEST,
    S_ZFIX,
    S_EMIT_REM,
    S_EMIT_ZERO,
    S_EMIT_TAIL
  } state_t;

  state_t                   state_r, state_nxt;
  logic [NUM_W-1:0]         num_r, num_nxt;
  logic [QUOT_W-1:0]        qest_r, qest_nxt;
  logic [NUM_W-1:0]         prod_r, prod_nxt;
  logic [UNIT_W-1:0]        units_r, units_nxt;
  logic [ZERO_W-1:0]        zq_r, zq_nxt;
  logic signed [BYTE_W-1:0] byte_r, byte_nxt;
  logic                     level_r, level_nxt;
  logic                     last_r, last_nxt;
  logic                     tail_r, tail_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_item_r, out_item_nxt;

  logic                     slot_free;
  logic [RPROD_W-1:0]       recip_prod;
  logic [NUM_W-1:0]         diff;
  logic [QUOT_W-1:0]        quot;
  logic [ZPROD_W-1:0]       zprod;
  logic [UNIT_W-1:0]        zrem;
  logic [REM_W-1:0]         rem7;
  logic [ZERO_W-1:0]        zq_fix;

  assign out_empty = !out_valid_r;
  assign out_data  = out_item_r;
  assign slot_free = !out_valid_r || out_pop;

  // Sequence one run through the converter and emitter
  always_comb begin
    state_nxt     = state_r;
    num_nxt       = num_r;
    qest_nxt      = qest_r;
    prod_nxt      = prod_r;
    units_nxt     = units_r;
    zq_nxt        = zq_r;
    byte_nxt      = byte_r;
    level_nxt     = level_r;
    last_nxt      = last_r;
    tail_nxt      = tail_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && !out_pop;
    q_pop         = 1'b0;
    recip_prod    = RPROD_W'(num_r) * RPROD_W'(RECIP_MUL);
    diff          = num_r - prod_r;
    quot          = qest_r + QUOT_W'(diff >= NUM_W'(UNIT_DIV));
    zprod         = ZPROD_W'(units_r) * ZPROD_W'(ZERO_RECIP);
    zrem          = units_r - UNIT_W'(zq_r) * UNIT_W'(ZERO_DIV);
    zq_fix        = zq_r;
    rem7          = '0;

    case (state_r)
      S_IDLE: begin
        // take the next run and form the rounded numerator
        if (!q_empty) begin
          q_pop     = 1'b1;
          num_nxt   = NUM_W'(q_head.count) * NUM_W'(UNIT_SCALE) + NUM_W'(ROUND_OFS);
          level_nxt = q_head.level_high;
          last_nxt  = q_head.last;
          tail_nxt  = q_head.tail;
          state_nxt = S_RECIP;
        end
      end
      S_RECIP: begin
        // quotient estimate, low by at most one
        qest_nxt  = recip_prod[RECIP_SHIFT +: QUOT_W];
        state_nxt = S_MULQ;
      end
      S_MULQ: begin
        prod_nxt  = NUM_W'(qest_r) * NUM_W'(UNIT_DIV);
        state_nxt = S_FIX;
      end
      S_FIX: begin
        // correct the estimate and clamp
        if (quot > QUOT_W'(MAX_UNITS)) begin
          units_nxt = UNIT_W'(MAX_UNITS);
        end else begin
          units_nxt = UNIT_W'(quot);
        end
        state_nxt = S_ZEST;
      end
      S_ZEST: begin
        zq_nxt    = ZERO_W'(zprod >> ZERO_SHIFT);
        state_nxt = S_ZFIX;
      end
      S_ZFIX: begin
        // correct zero count, form the signed remainder byte
        if (zrem >= UNIT_W'(ZERO_DIV)) begin
          zq_fix = zq_r + 1'b1;
          rem7   = REM_W'(zrem - UNIT_W'(ZERO_DIV));
        end else begin
          rem7   = REM_W'(zrem);
        end
        if (rem7 == '0) begin
          rem7 = REM_W'(1);
        end
        zq_nxt    = zq_fix;
        byte_nxt  = level_r ? $signed({1'b0, rem7}) : -$signed({1'b0, rem7});
        state_nxt = S_EMIT_REM;
      end
      S_EMIT_REM: begin
        if (slot_free) begin
          out_valid_nxt              = 1'b1;
          out_item_nxt.lep_byte      = byte_r;
          out_item_nxt.last_in_burst = last_r && !tail_r && (zq_r == '0);
          if (zq_r != '0) begin
            state_nxt = S_EMIT_ZERO;
          end else if (tail_r) begin
            state_nxt = S_EMIT_TAIL;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_EMIT_ZERO: begin
        if (slot_free) begin
          out_valid_nxt              = 1'b1;
          out_item_nxt.lep_byte      = LEP_ZERO;
          out_item_nxt.last_in_burst = last_r && !tail_r && (zq_r == ZERO_W'(1));
          zq_nxt                     = zq_r - 1'b1;
          if (zq_r == ZERO_W'(1)) begin
            state_nxt = tail_r ? S_EMIT_TAIL : S_IDLE;
          end
        end
      end
      S_EMIT_TAIL: begin
        // flushed empty run of the opposite level
        if (slot_free) begin
          out_valid_nxt              = 1'b1;
          out_item_nxt.lep_byte      = level_r ? LEP_MINUS_ONE : LEP_ONE;
          out_item_nxt.last_in_burst = 1'b1;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state, datapath and the result register
  always_ff @(posedge clk) begin
    num_r      <= num_nxt;
    qest_r     <= qest_nxt;
    prod_r     <= prod_nxt;
    units_r    <= units_nxt;
    zq_r       <= zq_nxt;
    byte_r     <= byte_nxt;
    level_r    <= level_nxt;
    last_r     <= last_nxt;
    tail_r     <= tail_nxt;
    out_item_r <= out_item_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tlre_checker.sv
// ----------------------------------------------------------------------------
// Tape level run encoder - port checker
// Watches the result port for byte range, stall behavior and burst continuity.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tape_level_run_encoder_defines.svh"

module tlre_checker import tlre_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_empty,
  input wire logic      out_pop,
  input wire out_item_t out_data
);

  // A stalled result stays put
  `TLRE_ASSERT_NEXT(a_out_hold, !out_empty && !out_pop, !out_empty && $stable(out_data), "result changed while stalled")

  // Run bytes never reach the most negative code
  `TLRE_ASSERT_IMP(a_no_min_byte, !out_empty, out_data.lep_byte != 8'h80, "run byte out of range")

  // Within a burst the next byte follows the taken one without a gap
  `TLRE_ASSERT_NEXT(a_burst_cont, !out_empty && out_pop && !out_data.last_in_burst, !out_empty, "gap inside a burst")

endmodule

bind tape_level_run_encoder tlre_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);

`default_nettype wire
